// ----- rtl/ddmc_pkg.sv -----
// Package for the differential drive motor command block.
// Holds the beat types, configuration codes and fixed constants.
// No dependencies; every other file but ddmc_chan_if imports it.
`default_nettype none

package ddmc_pkg;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_LINEAR = 2'd0;
  localparam logic [1:0] CMD_ROTATE = 2'd1;
  localparam logic [1:0] CMD_SKID   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_MAX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_SLOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_SLOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_MIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIANS   = 3'd6;

  // Fixed offsets added to the minimum outputs.
  localparam int LINEAR_OFFSET_EXTRA = 0;
  localparam int TURN_OFFSET_EXTRA   = 0;
  localparam int SKID_OFFSET_EXTRA   = 0;

  // Angle constants in Q4.12 radians and the output limit.
  localparam int TWO_PI_Q12  = 25736;
  localparam int PI_Q12      = 12868;
  localparam int WRAP_BIAS   = 3 * TWO_PI_Q12;
  localparam int DRIVE_LIMIT = 2047;

  // Divider geometry: 8 quotient bits, 23 bit dividend.
  localparam int unsigned QUO_W = 8;
  localparam int unsigned REM_W = 23;

  // Input beat.
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] distance_now;
    logic signed [15:0] distance_target;
    logic signed [15:0] heading_now;
    logic signed [15:0] heading_target;
  } ddmc_cmd_t;

  // Output beat.
  typedef struct packed {
    logic signed [11:0] left_drive;
    logic signed [11:0] right_drive;
  } ddmc_drive_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]  lin_max;
    logic [14:0] lin_slow;
    logic [7:0]  turn_max;
    logic [14:0] turn_slow;
    logic [7:0]  lin_min;
    logic [7:0]  turn_min;
    logic        radians;
  } ddmc_cfg_t;

  // Errors after the first front stage.
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [16:0] lin_err;
    logic signed [16:0] turn_err;
  } ddmc_err_t;

  // One division lane as it travels through the cell row.
  typedef struct packed {
    logic             neg;
    logic             nz;
    logic             forced;
    logic [7:0]       fval;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } ddmc_lane_t;

  // Beat handed from cell to cell.
  typedef struct packed {
    logic [1:0] cmd;
    ddmc_lane_t lin;
    ddmc_lane_t turn;
  } ddmc_div_t;

endpackage

`default_nettype wire

// ----- rtl/ddmc_chan_if.sv -----
// Valid/ready channel used for the input and output beats.
// The payload type is set where the channel is instantiated.
`default_nettype none

interface ddmc_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- rtl/ddmc_front.sv -----
// Front end: error computation with heading wrap, then magnitude,
// saturation check and dividend product. Two register stages. Uses ddmc_pkg.
`default_nettype none

module ddmc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ddmc_pkg::ddmc_cfg_t   cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ddmc_pkg::ddmc_cmd_t   data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ddmc_pkg::ddmc_div_t   data_o
);
  import ddmc_pkg::*;

  logic               err_vld_q;
  ddmc_err_t          err_q;
  ddmc_err_t          err_d;
  logic               err_rdy;
  logic               div_vld_q;
  ddmc_div_t          div_q;
  ddmc_div_t          div_d;

  logic signed [16:0] head_diff;
  logic signed [16:0] head_plain;
  logic [17:0]        wrap_sum;
  logic [17:0]        wrap_red;
  logic [14:0]        wrap_mod;
  logic signed [16:0] wrap_d;

  // Build one lane: magnitude, saturation and the dividend |err| * max.
  function automatic ddmc_lane_t lane_init(logic signed [16:0] err,
                                           logic [7:0] maxo,
                                           logic [14:0] slow);
    ddmc_lane_t l;
    logic [16:0] mag;
    logic        sat;
    mag      = err[16] ? (~err + 17'd1) : err;
    sat      = mag > {2'b00, slow};
    l.neg    = err[16];
    l.nz     = (err != '0);
    l.forced = sat || (slow == '0);
    l.fval   = sat ? maxo : 8'd0;
    l.rem    = REM_W'(mag[14:0]) * REM_W'(maxo);
    l.quo    = '0;
    return l;
  endfunction

  // Linear and heading differences; the turn error picks the wrapped or
  // the plain heading difference.
  always_comb begin
    head_diff  = signed'({data_i.heading_target[15], data_i.heading_target})
               - signed'({data_i.heading_now[15], data_i.heading_now});
    head_plain = signed'({data_i.heading_now[15], data_i.heading_now})
               - signed'({data_i.heading_target[15], data_i.heading_target});
    err_d.cmd  = data_i.cmd;
    err_d.lin_err = signed'({data_i.distance_now[15], data_i.distance_now})
                  - signed'({data_i.distance_target[15], data_i.distance_target});
    err_d.turn_err = cfg_i.radians ? -wrap_d : head_plain;
  end

  // Reduce the heading difference modulo two pi, then fold into (-pi, pi].
  always_comb begin
    wrap_sum = {head_diff[16], head_diff} + 18'(WRAP_BIAS);
    if (wrap_sum >= 18'(5 * TWO_PI_Q12)) begin
      wrap_red = wrap_sum - 18'(5 * TWO_PI_Q12);
    end else if (wrap_sum >= 18'(4 * TWO_PI_Q12)) begin
      wrap_red = wrap_sum - 18'(4 * TWO_PI_Q12);
    end else if (wrap_sum >= 18'(3 * TWO_PI_Q12)) begin
      wrap_red = wrap_sum - 18'(3 * TWO_PI_Q12);
    end else if (wrap_sum >= 18'(2 * TWO_PI_Q12)) begin
      wrap_red = wrap_sum - 18'(2 * TWO_PI_Q12);
    end else if (wrap_sum >= 18'(TWO_PI_Q12)) begin
      wrap_red = wrap_sum - 18'(TWO_PI_Q12);
    end else begin
      wrap_red = wrap_sum;
    end
    wrap_mod = wrap_red[14:0];
    wrap_d   = signed'({2'b00, wrap_mod})
             - ((wrap_mod > 15'(PI_Q12)) ? 17'sd25736 : 17'sd0);
  end

  // Second stage payload.
  always_comb begin
    div_d.cmd  = err_q.cmd;
    div_d.lin  = lane_init(err_q.lin_err, cfg_i.lin_max, cfg_i.lin_slow);
    div_d.turn = lane_init(err_q.turn_err, cfg_i.turn_max, cfg_i.turn_slow);
  end

  assign err_rdy = !div_vld_q || ready_i;
  assign ready_o = !err_vld_q || err_rdy;

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_vld_q <= 1'b0;
      div_vld_q <= 1'b0;
    end else begin
      if (ready_o) err_vld_q <= valid_i;
      if (err_rdy) div_vld_q <= err_vld_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) err_q <= err_d;
    if (err_rdy && err_vld_q) div_q <= div_d;
  end

  assign valid_o = div_vld_q;
  assign data_o  = div_q;

endmodule

`default_nettype wire

// ----- rtl/ddmc_cell.sv -----
// One cell of the divider row: a compare and subtract for one quotient bit
// on both the linear and the turn lane, then a register. Uses ddmc_pkg.
`default_nettype none

module ddmc_cell #(
  parameter int unsigned BIT = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ddmc_pkg::ddmc_cfg_t   cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ddmc_pkg::ddmc_div_t   data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ddmc_pkg::ddmc_div_t   data_o
);
  import ddmc_pkg::*;

  logic      vld_q;
  ddmc_div_t data_q;
  ddmc_div_t data_d;

  // Restoring step: take the divisor shifted to this bit if it fits.
  function automatic ddmc_lane_t lane_step(ddmc_lane_t l, logic [14:0] dvs);
    ddmc_lane_t  r;
    logic [REM_W-1:0] sh;
    r  = l;
    sh = REM_W'(dvs) << BIT;
    if (l.rem >= sh) begin
      r.rem      = l.rem - sh;
      r.quo[BIT] = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    data_d.cmd  = data_i.cmd;
    data_d.lin  = lane_step(data_i.lin, cfg_i.lin_slow);
    data_d.turn = lane_step(data_i.turn, cfg_i.turn_slow);
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  // The partial remainder must stay below the divisor scaled past this bit.
  a_lin_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !data_i.lin.forced
      |-> data_i.lin.rem < ((REM_W + 1)'(cfg_i.lin_slow) << (BIT + 1)))
    else $error("linear remainder out of range at cell %0d", BIT);
`endif

endmodule

`default_nettype wire

// ----- rtl/ddmc_back.sv -----
// Back end: minimum offsets, direction, skid mixing and saturation,
// then the output register. Uses ddmc_pkg.
`default_nettype none

module ddmc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ddmc_pkg::ddmc_cfg_t   cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ddmc_pkg::ddmc_div_t   data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ddmc_pkg::ddmc_drive_t data_o
);
  import ddmc_pkg::*;

  logic               vld_q;
  ddmc_drive_t        drive_q;
  ddmc_drive_t        drive_d;

  logic [7:0]         lin_y;
  logic [7:0]         turn_y;
  logic [9:0]         lin_mag;
  logic [9:0]         turn_mag;
  logic signed [9:0]  skid_adj;
  logic signed [12:0] lin_v;
  logic signed [12:0] turn_l;
  logic signed [12:0] turn_r;
  logic signed [12:0] skid_l;
  logic signed [12:0] skid_r;
  logic               turn_pos;

  // Clamp to the symmetric drive range.
  function automatic logic signed [11:0] clamp(logic signed [12:0] v);
    logic signed [12:0] c;
    c = v;
    if (v > 13'(DRIVE_LIMIT)) c = 13'(DRIVE_LIMIT);
    if (v < -13'(DRIVE_LIMIT)) c = -13'(DRIVE_LIMIT);
    return c[11:0];
  endfunction

  // Move a rotational wheel value by the skid adjustment toward zero.
  function automatic logic signed [12:0] skid_move(logic signed [12:0] w,
                                                   logic signed [9:0] a);
    return (w < 0) ? (w + 13'(a)) : (w - 13'(a));
  endfunction

  always_comb begin
    lin_y    = data_i.lin.forced ? data_i.lin.fval : data_i.lin.quo;
    turn_y   = data_i.turn.forced ? data_i.turn.fval : data_i.turn.quo;
    lin_mag  = 10'(lin_y) + 10'(cfg_i.lin_min) + 10'(LINEAR_OFFSET_EXTRA);
    turn_mag = 10'(turn_y) + 10'(cfg_i.turn_min) + 10'(TURN_OFFSET_EXTRA);
    skid_adj = signed'(10'(cfg_i.turn_min)) - signed'(10'(SKID_OFFSET_EXTRA));

    // A zero proportional term counts as positive and takes the plus offset.
    lin_v = (data_i.lin.neg && (lin_y != '0)) ? -signed'(13'(lin_mag))
                                              : signed'(13'(lin_mag));
    turn_pos = !data_i.turn.neg && data_i.turn.nz;
    turn_l   = turn_pos ? signed'(13'(turn_mag)) : -signed'(13'(turn_mag));
    turn_r   = -turn_l;
    skid_l   = skid_move(turn_l, skid_adj) + lin_v;
    skid_r   = skid_move(turn_r, skid_adj) + lin_v;

    case (data_i.cmd)
      CMD_LINEAR: begin
        drive_d.left_drive  = clamp(lin_v);
        drive_d.right_drive = clamp(lin_v);
      end
      CMD_ROTATE: begin
        drive_d.left_drive  = clamp(turn_l);
        drive_d.right_drive = clamp(turn_r);
      end
      CMD_SKID: begin
        drive_d.left_drive  = clamp(skid_l);
        drive_d.right_drive = clamp(skid_r);
      end
      default: begin
        drive_d.left_drive  = '0;
        drive_d.right_drive = '0;
      end
    endcase
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) drive_q <= drive_d;
  end

  assign valid_o = vld_q;
  assign data_o  = drive_q;

`ifndef SYNTHESIS
  // A linear command drives both wheels alike.
  a_linear_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (data_i.cmd == CMD_LINEAR)
      |-> drive_d.left_drive == drive_d.right_drive)
    else $error("linear command gave unequal wheels");

  // A rotational command spins the wheels in opposite directions.
  a_rotate_opposite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (data_i.cmd == CMD_ROTATE)
      |-> drive_d.left_drive == -drive_d.right_drive)
    else $error("rotational command gave wheels that do not oppose");
`endif

endmodule

`default_nettype wire

// ----- rtl/differential_drive_motor_command.sv -----
// Differential drive motor command: a stateless proportional controller
// with saturation for a two wheel base.
//
// Channels: cmd_ch takes one command beat (cmd, distance now/target,
// heading now/target); drv_ch returns one beat with left and right drive.
// Each beat is taken when valid and ready are both high. Registers are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i, one per cycle, and
// must only change while no command is in flight.
//
// An accepted command reaches its drive beat through two front stages
// (error and wrap, then magnitude and product), a row of eight divider
// cells that each settle one quotient bit, and the output register. One
// command is accepted every cycle unless a stalled receiver has filled the pipeline.
//
// Every stage has its own valid bit and ready, so a stalled receiver holds
// the output beat while earlier stages keep filling empty slots; input
// ready drops only when every stage is full. Reset empties the pipeline
// and loads the register defaults.
`default_nettype none

module differential_drive_motor_command (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ddmc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ddmc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  ddmc_chan_if.sink                          cmd_ch,
  ddmc_chan_if.source                        drv_ch
);
  import ddmc_pkg::*;

  localparam int unsigned NCELL = QUO_W;

  ddmc_cfg_t   cfg_q;
  ddmc_cmd_t   cmd_pl;
  ddmc_drive_t drv_pl;

  logic [NCELL:0] row_vld;
  logic [NCELL:0] row_rdy;
  ddmc_div_t      row_pl [NCELL+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lin_max   <= 8'd100;
      cfg_q.lin_slow  <= 15'd256;
      cfg_q.turn_max  <= 8'd100;
      cfg_q.turn_slow <= 15'd2048;
      cfg_q.lin_min   <= 8'd0;
      cfg_q.turn_min  <= 8'd0;
      cfg_q.radians   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIN_MAX:   cfg_q.lin_max   <= cfg_wdata_i[7:0];
        CFG_LIN_SLOW:  cfg_q.lin_slow  <= cfg_wdata_i[14:0];
        CFG_TURN_MAX:  cfg_q.turn_max  <= cfg_wdata_i[7:0];
        CFG_TURN_SLOW: cfg_q.turn_slow <= cfg_wdata_i[14:0];
        CFG_LIN_MIN:   cfg_q.lin_min   <= cfg_wdata_i[7:0];
        CFG_TURN_MIN:  cfg_q.turn_min  <= cfg_wdata_i[7:0];
        CFG_RADIANS:   cfg_q.radians   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cmd_pl = cmd_ch.payload;

  // Error, wrap and dividend stages.
  ddmc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (cmd_ch.valid),
    .ready_o (cmd_ch.ready),
    .data_i  (cmd_pl),
    .valid_o (row_vld[0]),
    .ready_i (row_rdy[0]),
    .data_o  (row_pl[0])
  );

  // Divider row, most significant quotient bit first.
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    ddmc_cell #(
      .BIT (NCELL - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg_q),
      .valid_i (row_vld[g]),
      .ready_o (row_rdy[g]),
      .data_i  (row_pl[g]),
      .valid_o (row_vld[g+1]),
      .ready_i (row_rdy[g+1]),
      .data_o  (row_pl[g+1])
    );
  end

  // Offsets, mixing, saturation and output register.
  ddmc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (row_vld[NCELL]),
    .ready_o (row_rdy[NCELL]),
    .data_i  (row_pl[NCELL]),
    .valid_o (drv_ch.valid),
    .ready_i (drv_ch.ready),
    .data_o  (drv_pl)
  );

  assign drv_ch.payload = drv_pl;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the differential drive motor command block.
// Depends on ddmc_pkg, the ddmc_chan_if channel interface and the block's RTL.
// Every drive beat is checked against a built-in predictor of the controller.
`timescale 1ns / 1ps

module tb_top;
  import ddmc_pkg::*;

  // Command code that the block does not use; it must give zero drive.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int FULL_TURN = 25736;
  localparam int HALF_TURN = 12868;
  localparam int HEADING_LIMIT = 25736;
  localparam int DRIVE_CLAMP = 2047;
  localparam int LONG_HOLD = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ddmc_chan_if #(.payload_t(ddmc_cmd_t)) cmd_ch ();
  ddmc_chan_if #(.payload_t(ddmc_drive_t)) drv_ch ();

  differential_drive_motor_command i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .cmd_ch     (cmd_ch),
    .drv_ch     (drv_ch)
  );

  // Register values as the block holds them, and the drive beats still owed.
  ddmc_cfg_t gains;
  ddmc_drive_t pending_drives[$];
  ddmc_drive_t want;
  int mismatches;
  int quiet_cycles;
  logic [1:0] legal_cmds[3];

  // Idling controls and the long receiver hold-off request.
  bit sender_gaps;
  bit receiver_stalls;
  int hold_req_cnt;
  int hold_seen;
  int hold_left;
  int stall_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Clamp a value into a closed range.
  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Proportional magnitude that saturates beyond the slowdown point.
  function automatic int scaled_mag(input int unsigned mag, input int unsigned top,
                                    input int unsigned slow);
    longint unsigned prod;
    if (mag > slow) return int'(top);
    if (slow == 0) return 0;
    prod = mag;
    prod = prod * top;
    return int'(prod / slow);
  endfunction

  // Linear drive from the distance error, pushed away from zero by the minimum.
  function automatic int linear_term(input int dnow, input int dtgt);
    int err;
    int v;
    int off;
    err = dnow - dtgt;
    v = scaled_mag((err < 0) ? -err : err, gains.lin_max, gains.lin_slow);
    off = int'(gains.lin_min) + LINEAR_OFFSET_EXTRA;
    if (err < 0) v = -v;
    return (v >= 0) ? v + off : v - off;
  endfunction

  // Opposite wheel spin from the heading error, wrapped in radian mode.
  function automatic void turn_terms(input int hnow, input int htgt,
                                     output int l, output int r);
    int d;
    int err;
    int m;
    if (gains.radians) begin
      d = (htgt - hnow) % FULL_TURN;
      if (d < 0) d += FULL_TURN;
      if (d > HALF_TURN) d -= FULL_TURN;
      err = -d;
    end else begin
      err = hnow - htgt;
    end
    m = scaled_mag((err < 0) ? -err : err, gains.turn_max, gains.turn_slow)
        + int'(gains.turn_min) + TURN_OFFSET_EXTRA;
    if (err <= 0) begin
      l = -m;
      r = m;
    end else begin
      l = m;
      r = -m;
    end
  endfunction

  // Expected wheel drives for one command under the current registers.
  function automatic ddmc_drive_t drive_for_command(input ddmc_cmd_t c);
    ddmc_drive_t d;
    int lin;
    int l;
    int r;
    int adj;
    l = 0;
    r = 0;
    case (c.cmd)
      CMD_LINEAR: begin
        l = linear_term(c.distance_now, c.distance_target);
        r = l;
      end
      CMD_ROTATE: begin
        turn_terms(c.heading_now, c.heading_target, l, r);
      end
      CMD_SKID: begin
        lin = linear_term(c.distance_now, c.distance_target);
        turn_terms(c.heading_now, c.heading_target, l, r);
        adj = int'(gains.turn_min) - SKID_OFFSET_EXTRA;
        l = ((l < 0) ? l + adj : l - adj) + lin;
        r = ((r < 0) ? r + adj : r - adj) + lin;
      end
      default: begin
      end
    endcase
    d.left_drive = 12'(clamp_int(l, -DRIVE_CLAMP, DRIVE_CLAMP));
    d.right_drive = 12'(clamp_int(r, -DRIVE_CLAMP, DRIVE_CLAMP));
    return d;
  endfunction

  function automatic ddmc_cmd_t make_cmd(input logic [1:0] op, input int dn, input int dt,
                                         input int hn, input int ht);
    ddmc_cmd_t c;
    c.cmd = op;
    c.distance_now = 16'(dn);
    c.distance_target = 16'(dt);
    c.heading_now = 16'(hn);
    c.heading_target = 16'(ht);
    return c;
  endfunction

  // Random command; errors are steered into the proportional band, onto the
  // half-turn boundary and onto full turns as well as across the whole range.
  function automatic ddmc_cmd_t random_command();
    int dnow;
    int dtgt;
    int hnow;
    int htgt;
    int span;
    int dir;
    dnow = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 3))
      0: dtgt = int'($urandom_range(0, 65535)) - 32768;
      3: dtgt = dnow + int'($urandom_range(0, 2)) - 1;
      default: begin
        span = int'(gains.lin_slow) + 2;
        dtgt = dnow + int'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    hnow = int'($urandom_range(0, 2 * HEADING_LIMIT)) - HEADING_LIMIT;
    dir = ($urandom_range(0, 1) == 0) ? -1 : 1;
    case ($urandom_range(0, 4))
      0: htgt = int'($urandom_range(0, 2 * HEADING_LIMIT)) - HEADING_LIMIT;
      1: htgt = hnow + dir * HALF_TURN + int'($urandom_range(0, 6)) - 3;
      2: htgt = hnow + dir * FULL_TURN + int'($urandom_range(0, 2)) - 1;
      default: begin
        span = int'(gains.turn_slow) + 2;
        htgt = hnow + int'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    return make_cmd(($urandom_range(0, 31) == 0) ? CMD_UNUSED
                                                 : legal_cmds[$urandom_range(0, 2)],
                    dnow, clamp_int(dtgt, -32768, 32767),
                    hnow, clamp_int(htgt, -HEADING_LIMIT, HEADING_LIMIT));
  endfunction

  // Pick the low end, the high end or anything in between.
  function automatic int pick_value(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return int'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic ddmc_cfg_t random_settings();
    ddmc_cfg_t s;
    s.lin_max = 8'(pick_value(0, 255));
    s.lin_slow = 15'(($urandom_range(0, 1) == 0) ? pick_value(1, 600) : pick_value(1, 32767));
    s.turn_max = 8'(pick_value(0, 255));
    s.turn_slow = 15'(($urandom_range(0, 1) == 0) ? pick_value(1, 4096) : pick_value(1, 32767));
    s.lin_min = 8'(pick_value(0, 255));
    s.turn_min = 8'(pick_value(0, 255));
    s.radians = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Offer one command beat, after an optional idle burst, until it is taken.
  task automatic send_cmd(input ddmc_cmd_t c);
    int gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= c;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Stop offering and wait until every owed drive beat has come back.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_drives.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write all seven registers while the block is empty.
  task automatic load_settings(input ddmc_cfg_t s);
    wait_drained();
    write_reg(CFG_LIN_MAX, 15'(s.lin_max));
    write_reg(CFG_LIN_SLOW, s.lin_slow);
    write_reg(CFG_TURN_MAX, 15'(s.turn_max));
    write_reg(CFG_TURN_SLOW, s.turn_slow);
    write_reg(CFG_LIN_MIN, 15'(s.lin_min));
    write_reg(CFG_TURN_MIN, 15'(s.turn_min));
    write_reg(CFG_RADIANS, 15'(s.radians));
    cfg_we <= 1'b0;
    gains = s;
  endtask

  // Register defaults: proportional band edges, wrap at exactly half a turn,
  // full-turn differences and the unused command code.
  task automatic test_reset_defaults();
    sender_gaps = 1'b1;
    receiver_stalls <= 1'b1;
    send_cmd(make_cmd(CMD_LINEAR, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_LINEAR, 256, 0, 0, 0));
    send_cmd(make_cmd(CMD_LINEAR, 257, 0, 0, 0));
    send_cmd(make_cmd(CMD_LINEAR, -1, 0, 0, 0));
    send_cmd(make_cmd(CMD_LINEAR, 32767, -32768, 0, 0));
    send_cmd(make_cmd(CMD_LINEAR, -32768, 32767, 0, 0));
    send_cmd(make_cmd(CMD_ROTATE, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_ROTATE, 0, 0, 0, HALF_TURN));
    send_cmd(make_cmd(CMD_ROTATE, 0, 0, 0, -HALF_TURN));
    send_cmd(make_cmd(CMD_ROTATE, 0, 0, 0, HALF_TURN + 1));
    send_cmd(make_cmd(CMD_ROTATE, 0, 0, -HEADING_LIMIT, HEADING_LIMIT));
    send_cmd(make_cmd(CMD_ROTATE, 0, 0, 100, 0));
    send_cmd(make_cmd(CMD_SKID, 512, 0, 0, 300));
    send_cmd(make_cmd(CMD_UNUSED, 1234, -1234, 500, -500));
  endtask

  // Widest settings first, then the narrowest, in both heading modes.
  task automatic test_extreme_settings();
    load_settings('{lin_max: 255, lin_slow: 1, turn_max: 255, turn_slow: 1,
                    lin_min: 255, turn_min: 255, radians: 0});
    send_cmd(make_cmd(CMD_LINEAR, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_LINEAR, 1, 0, 0, 0));
    send_cmd(make_cmd(CMD_LINEAR, -32768, 32767, 0, 0));
    send_cmd(make_cmd(CMD_ROTATE, 0, 0, HEADING_LIMIT, -HEADING_LIMIT));
    send_cmd(make_cmd(CMD_ROTATE, 0, 0, -HEADING_LIMIT, HEADING_LIMIT));
    send_cmd(make_cmd(CMD_SKID, 32767, -32768, -HEADING_LIMIT, HEADING_LIMIT));
    send_cmd(make_cmd(CMD_SKID, 0, 0, 0, 0));
    load_settings('{lin_max: 0, lin_slow: 32767, turn_max: 0, turn_slow: 32767,
                    lin_min: 0, turn_min: 0, radians: 1});
    send_cmd(make_cmd(CMD_LINEAR, 32767, -32768, 0, 0));
    send_cmd(make_cmd(CMD_SKID, 100, 0, 5000, 0));
  endtask

  // A slowdown point of zero: any nonzero error saturates, zero error gives zero.
  task automatic test_zero_slowdown();
    load_settings('{lin_max: 200, lin_slow: 0, turn_max: 150, turn_slow: 0,
                    lin_min: 10, turn_min: 20, radians: 1});
    send_cmd(make_cmd(CMD_LINEAR, 5, 5, 0, 0));
    send_cmd(make_cmd(CMD_LINEAR, 6, 5, 0, 0));
    send_cmd(make_cmd(CMD_ROTATE, 0, 0, 0, 0));
    send_cmd(make_cmd(CMD_SKID, 3, 0, 40, 0));
  endtask

  // Several random register settings, each with a batch of random commands.
  task automatic test_random_settings();
    ddmc_cfg_t s;
    for (int phase = 0; phase < 6; phase++) begin
      s = random_settings();
      s.radians = 1'(phase % 2);
      load_settings(s);
      sender_gaps = (phase != 2);
      receiver_stalls <= (phase != 3);
      repeat (140) send_cmd(random_command());
    end
  endtask

  // The receiver holds off for a long stretch while commands keep coming,
  // so the pipeline fills and the input stalls.
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    receiver_stalls <= 1'b0;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (60) send_cmd(random_command());
  endtask

  // The sender stops until all owed beats are back, then resumes.
  task automatic test_sender_pause();
    sender_gaps = 1'b1;
    receiver_stalls <= 1'b1;
    repeat (3) begin
      repeat (25) send_cmd(random_command());
      wait_drained();
    end
  endtask

  // Back-to-back beats on both sides to close the run.
  task automatic test_full_rate();
    sender_gaps = 1'b0;
    receiver_stalls <= 1'b0;
    repeat (150) send_cmd(random_command());
  endtask

  // Receiver ready: a requested long hold-off first, then random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_ch.ready <= 1'b0;
    end else if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = LONG_HOLD - 1;
      drv_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      drv_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      drv_ch.ready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      drv_ch.ready <= 1'b0;
    end else begin
      drv_ch.ready <= 1'b1;
    end
  end

  // Predict on every accepted command beat; check every accepted drive beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cmd_ch.valid && cmd_ch.ready)
        pending_drives.push_back(drive_for_command(cmd_ch.payload));
      if (drv_ch.valid && drv_ch.ready) begin
        if (pending_drives.size() == 0) begin
          $display("%0t: unexpected drive beat, left %0d right %0d", $time,
                   drv_ch.payload.left_drive, drv_ch.payload.right_drive);
          mismatches++;
        end else begin
          want = pending_drives.pop_front();
          if (drv_ch.payload.left_drive !== want.left_drive) begin
            $display("%0t: left_drive expected %0d, got %0d", $time,
                     want.left_drive, drv_ch.payload.left_drive);
            mismatches++;
          end
          if (drv_ch.payload.right_drive !== want.right_drive) begin
            $display("%0t: right_drive expected %0d, got %0d", $time,
                     want.right_drive, drv_ch.payload.right_drive);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (drv_ch.valid && drv_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d drive beats outstanding", $time,
                 quiet_cycles, pending_drives.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.payload = '0;
    drv_ch.ready = 1'b0;
    legal_cmds = '{CMD_LINEAR, CMD_ROTATE, CMD_SKID};
    gains = '{lin_max: 100, lin_slow: 256, turn_max: 100, turn_slow: 2048,
              lin_min: 0, turn_min: 0, radians: 1};
    mismatches = 0;
    quiet_cycles = 0;
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    hold_req_cnt = 0;
    hold_seen = 0;
    hold_left = 0;
    stall_left = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_extreme_settings();
    test_zero_slowdown();
    test_random_settings();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();

    // Let the last beats drain and make sure nothing extra follows.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
